[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the table design
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EHT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("eht assertion failed");
`define EHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eht assertion failed");
`else
`define EHT_ASSERT(lbl, clk, rst_n, prop)
`define EHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/eht_pkg.sv]
// ----------------------------------------------------------------------------
// eht_pkg
// types and constants of the encounter hysteresis table
// ----------------------------------------------------------------------------
package eht_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int ID_BITS_DEF       = 16;
    localparam int QUEUE_DEPTH       = 2;
    localparam int CMD_BITS          = 2;
    localparam int ADDR_BITS         = 5;

    typedef enum logic [1:0] {
        ACT_DISC   = 2'd0,
        ACT_CONF   = 2'd1,
        ACT_SWEEP  = 2'd2,
        ACT_UNUSED = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CMD_DISC  = 2'd0,
        CMD_NOMEM = 2'd1,
        CMD_CONF  = 2'd2,
        CMD_SWEEP = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_NEW     = 3'd0,
        KIND_HS      = 3'd1,
        KIND_EXPIRED = 3'd2,
        KIND_FULL    = 3'd3,
        KIND_DONE    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        REG_MODE     = 3'd0,
        REG_MIN_MS   = 3'd1,
        REG_MAX_MS   = 3'd2,
        REG_SEEN_CNT = 3'd3,
        REG_END_MS   = 3'd4,
        REG_RSSI_THR = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]        scheme_mode;
        logic [31:0]       min_start_ms;
        logic [31:0]       max_start_ms;
        logic [7:0]        start_seen_count;
        logic [31:0]       end_ms;
        logic signed [7:0] rssi_threshold;
    } cfg_t;

endpackage

[design/eht_in_if.sv]
// ----------------------------------------------------------------------------
// eht_in_if
// input channel: one sighting, confirm or sweep word
// ----------------------------------------------------------------------------
interface eht_in_if #(
    parameter int ID_BITS = eht_pkg::ID_BITS_DEF
);
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [ID_BITS-1:0] device_id;
    logic signed [7:0]  rssi;
    logic [31:0]        now_ms;

    modport source (output valid, action, device_id, rssi, now_ms, input ready);
    modport sink   (input valid, action, device_id, rssi, now_ms, output ready);
endinterface

[design/eht_out_if.sv]
// ----------------------------------------------------------------------------
// eht_out_if
// output channel: one result word
// ----------------------------------------------------------------------------
interface eht_out_if #(
    parameter int ID_BITS = eht_pkg::ID_BITS_DEF
);
    logic               valid;
    logic               ready;
    logic [2:0]         out_kind;
    logic [ID_BITS-1:0] out_device_id;
    logic [31:0]        out_time_ms;
    logic               out_last;

    modport source (output valid, out_kind, out_device_id, out_time_ms, out_last,
                    input ready);
    modport sink   (input valid, out_kind, out_device_id, out_time_ms, out_last,
                    output ready);
endinterface

[design/encounter_hysteresis_table.sv]
// ----------------------------------------------------------------------------
// encounter_hysteresis_table
// encounter detection table of nearby radio devices, with apb register port
// ----------------------------------------------------------------------------
// channel   dir  handshake      payload
// in_ch     in   valid/ready    action, device_id, rssi, now_ms
// out_ch    out  valid/ready    out_kind, out_device_id, out_time_ms, out_last
// apb       in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// a lookup or sweep walks the table one entry a cycle over a single read port,
// except while a sweep waits on a stalled output; a lookup stops at its first hit
// a no-memory discovery bypasses the table and goes straight to result output
// reset clears all valid bits at once; there is no clearing pass
// a stalled output holds the sweep at the expiring entry; the queue keeps
// accepting up to two words meanwhile
// ----------------------------------------------------------------------------
module encounter_hysteresis_table #(
    parameter int TABLE_ENTRIES = eht_pkg::TABLE_ENTRIES_DEF,
    parameter int ID_BITS       = eht_pkg::ID_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    eht_in_if.sink                        in_ch,
    eht_out_if.source                     out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [eht_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    localparam int CMD_W = eht_pkg::CMD_BITS + ID_BITS + 8 + 32;

    eht_pkg::cfg_t      cfg_reg;
    eht_pkg::reg_idx_t  reg_idx;
    logic               wr_en;
    logic               push, push_ready, pop, pop_valid;
    logic [CMD_W-1:0]   push_data, pop_data;

    assign pready  = 1'b1;
    assign reg_idx = eht_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scheme_mode      <= 2'd0;
            cfg_reg.min_start_ms     <= 32'd0;
            cfg_reg.max_start_ms     <= 32'd0;
            cfg_reg.start_seen_count <= 8'd1;
            cfg_reg.end_ms           <= 32'd0;
            cfg_reg.rssi_threshold   <= -8'sd128;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                eht_pkg::REG_MODE:     cfg_reg.scheme_mode      <= pwdata[1:0];
                eht_pkg::REG_MIN_MS:   cfg_reg.min_start_ms     <= pwdata;
                eht_pkg::REG_MAX_MS:   cfg_reg.max_start_ms     <= pwdata;
                eht_pkg::REG_SEEN_CNT: cfg_reg.start_seen_count <= pwdata[7:0];
                eht_pkg::REG_END_MS:   cfg_reg.end_ms           <= pwdata;
                eht_pkg::REG_RSSI_THR: cfg_reg.rssi_threshold   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            eht_pkg::REG_MODE:     prdata = {30'd0, cfg_reg.scheme_mode};
            eht_pkg::REG_MIN_MS:   prdata = cfg_reg.min_start_ms;
            eht_pkg::REG_MAX_MS:   prdata = cfg_reg.max_start_ms;
            eht_pkg::REG_SEEN_CNT: prdata = {24'd0, cfg_reg.start_seen_count};
            eht_pkg::REG_END_MS:   prdata = cfg_reg.end_ms;
            eht_pkg::REG_RSSI_THR: prdata = {24'd0, cfg_reg.rssi_threshold};
            default:               prdata = 32'd0;
        endcase
    end

    eht_front #(
        .ID_BITS (ID_BITS),
        .CMD_W   (CMD_W)
    ) u_front (
        .in_ch      (in_ch),
        .cfg        (cfg_reg),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    eht_queue #(
        .WIDTH (CMD_W),
        .DEPTH (eht_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    eht_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ID_BITS       (ID_BITS),
        .CMD_W         (CMD_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_ch    (out_ch)
    );
endmodule

[design/eht_queue.sv]
// ----------------------------------------------------------------------------
// eht_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module eht_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = eht_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

[design/eht_front.sv]
// ----------------------------------------------------------------------------
// eht_front
// accepts input words and classifies them into back-end commands
// ----------------------------------------------------------------------------
module eht_front #(
    parameter int ID_BITS = eht_pkg::ID_BITS_DEF,
    parameter int CMD_W   = eht_pkg::CMD_BITS + ID_BITS + 8 + 32
) (
    eht_in_if.sink           in_ch,
    input  eht_pkg::cfg_t    cfg,
    output logic             push,
    output logic [CMD_W-1:0] push_data,
    input  logic             push_ready
);
    eht_pkg::cmd_t cmd;

    always_comb
    begin
        unique case (eht_pkg::action_t'(in_ch.action))
            eht_pkg::ACT_DISC:
            begin
                // only the no-memory bit selects the table bypass
                cmd = cfg.scheme_mode[1] ? eht_pkg::CMD_NOMEM : eht_pkg::CMD_DISC;
            end
            eht_pkg::ACT_CONF:  cmd = eht_pkg::CMD_CONF;
            default:            cmd = eht_pkg::CMD_SWEEP;
        endcase
    end

    // unused action is accepted and dropped
    assign in_ch.ready = push_ready;
    assign push        = in_ch.valid && (in_ch.action != eht_pkg::ACT_UNUSED);
    assign push_data   = {cmd, in_ch.device_id, in_ch.rssi, in_ch.now_ms};
endmodule

[design/eht_back.sv]
// ----------------------------------------------------------------------------
// eht_back
// table walker: lookup, allocation, update, sweep and result output
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eht_back #(
    parameter int TABLE_ENTRIES = eht_pkg::TABLE_ENTRIES_DEF,
    parameter int ID_BITS       = eht_pkg::ID_BITS_DEF,
    parameter int CMD_W         = eht_pkg::CMD_BITS + ID_BITS + 8 + 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  eht_pkg::cfg_t    cfg,
    input  logic             pop_valid,
    input  logic [CMD_W-1:0] pop_data,
    output logic             pop,
    eht_out_if.source        out_ch
);
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // table store
    logic [ID_BITS-1:0] dev_mem   [TABLE_ENTRIES];
    logic               enc_mem   [TABLE_ENTRIES];
    logic [7:0]         seen_mem  [TABLE_ENTRIES];
    logic [31:0]        first_mem [TABLE_ENTRIES];
    logic [31:0]        last_mem  [TABLE_ENTRIES];

    logic [ID_BITS-1:0] rd_dev_reg;
    logic               rd_enc_reg;
    logic [7:0]         rd_seen_reg;
    logic [31:0]        rd_first_reg;
    logic [31:0]        rd_last_reg;

    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    eht_pkg::state_t    state_reg, state_next;
    eht_pkg::cmd_t      cmd_reg;
    logic [ID_BITS-1:0] id_reg;
    logic signed [7:0]  rssi_reg;
    logic [31:0]        now_reg;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               found_reg, found_next;
    logic               free_found_reg, free_found_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;
    logic               p_full_reg, p_full_next;
    logic               p_new_reg, p_new_next;
    logic               p_hs_reg, p_hs_next;
    logic               p_done_reg, p_done_next;

    logic               out_valid_reg;
    logic [2:0]         out_kind_reg;
    logic [ID_BITS-1:0] out_id_reg;
    logic [31:0]        out_time_reg;
    logic               out_last_reg;

    logic               can_load;
    logic               load_out;
    eht_pkg::kind_t     load_kind;
    logic [ID_BITS-1:0] load_id;
    logic [31:0]        load_time;
    logic               load_last;

    logic [IDX_W-1:0]   rd_addr;
    logic               proceed;
    logic               is_last;
    logic               cur_valid;
    logic               match;
    logic               expire;
    logic [31:0]        limit;

    logic               mem_we;
    logic [IDX_W-1:0]   wr_addr;
    logic               have_slot;
    logic               base_enc;
    logic [7:0]         base_seen;
    logic [31:0]        base_first;
    logic [7:0]         new_seen;
    logic               promo;
    logic               hs;
    logic               wr_enc;
    logic [7:0]         wr_seen;
    logic [31:0]        wr_first;
    logic [31:0]        wr_last;
    logic               is_disc;

    assign can_load  = !out_valid_reg || out_ch.ready;
    assign is_last   = (idx_reg == LAST_IDX);
    assign cur_valid = valid_reg[idx_reg];
    assign match     = cur_valid && (rd_dev_reg == id_reg);
    assign limit     = rd_enc_reg ? cfg.end_ms : cfg.max_start_ms;
    assign expire    = cur_valid && ((now_reg - rd_last_reg) > limit);
    assign is_disc   = (cmd_reg == eht_pkg::CMD_DISC);

    // update of the entry found or allocated
    always_comb
    begin
        have_slot  = found_reg || free_found_reg;
        wr_addr    = found_reg ? idx_reg : free_idx_reg;
        base_enc   = found_reg ? rd_enc_reg : (cmd_reg == eht_pkg::CMD_CONF);
        base_seen  = found_reg ? rd_seen_reg : 8'd0;
        base_first = found_reg ? rd_first_reg : now_reg;
        new_seen   = ((rssi_reg > cfg.rssi_threshold) && (base_seen != 8'hFF))
                     ? base_seen + 8'd1 : base_seen;
        promo      = !base_enc && (((new_seen >= cfg.start_seen_count) &&
                     ((now_reg - base_first) >= cfg.min_start_ms)) || cfg.scheme_mode[0]);
        hs         = base_enc || promo;
        if (is_disc)
        begin
            wr_enc  = hs;
            wr_seen = new_seen;
            wr_last = now_reg;
        end
        else
        begin
            wr_enc  = 1'b1;
            wr_seen = base_seen;
            wr_last = found_reg ? rd_last_reg : now_reg;
        end
        wr_first = base_first;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            eht_pkg::ST_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = (eht_pkg::cmd_t'(pop_data[CMD_W-1 -: eht_pkg::CMD_BITS])
                                  == eht_pkg::CMD_NOMEM) ? eht_pkg::ST_EMIT
                                                         : eht_pkg::ST_SCAN;
                end
            end
            eht_pkg::ST_SCAN:
            begin
                if (cmd_reg == eht_pkg::CMD_SWEEP)
                begin
                    if (proceed && is_last)
                    begin
                        state_next = eht_pkg::ST_EMIT;
                    end
                end
                else if (match || is_last)
                begin
                    state_next = eht_pkg::ST_UPD;
                end
            end
            eht_pkg::ST_UPD:
            begin
                state_next = (!have_slot || (is_disc && (hs || !found_reg)))
                             ? eht_pkg::ST_EMIT : eht_pkg::ST_IDLE;
            end
            eht_pkg::ST_EMIT:
            begin
                if (can_load && load_last)
                begin
                    state_next = eht_pkg::ST_IDLE;
                end
            end
            default: state_next = eht_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        pop             = 1'b0;
        proceed         = 1'b0;
        rd_addr         = '0;
        idx_next        = idx_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        p_full_next     = p_full_reg;
        p_new_next      = p_new_reg;
        p_hs_next       = p_hs_reg;
        p_done_next     = p_done_reg;
        valid_next      = valid_reg;
        mem_we          = 1'b0;
        load_out        = 1'b0;
        load_kind       = eht_pkg::KIND_DONE;
        load_id         = '0;
        load_time       = now_reg;
        load_last       = 1'b0;
        unique case (state_reg)
            eht_pkg::ST_IDLE:
            begin
                pop             = pop_valid;
                idx_next        = '0;
                found_next      = 1'b0;
                free_found_next = 1'b0;
                if (pop_valid && (eht_pkg::cmd_t'(pop_data[CMD_W-1 -: eht_pkg::CMD_BITS])
                                  == eht_pkg::CMD_NOMEM))
                begin
                    p_new_next = 1'b1;
                    p_hs_next  = 1'b1;
                end
            end
            eht_pkg::ST_SCAN:
            begin
                if (cmd_reg == eht_pkg::CMD_SWEEP)
                begin
                    proceed = !expire || can_load;
                    if (expire && can_load)
                    begin
                        load_out            = 1'b1;
                        load_kind           = eht_pkg::KIND_EXPIRED;
                        load_id             = rd_dev_reg;
                        load_time           = rd_last_reg;
                        valid_next[idx_reg] = 1'b0;
                    end
                    if (proceed && is_last)
                    begin
                        p_done_next = 1'b1;
                    end
                end
                else
                begin
                    proceed = !match;
                    if (!cur_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    found_next = match;
                end
                // the read address runs one entry ahead while the walk moves on
                rd_addr  = (proceed && !is_last) ? idx_reg + 1'b1 : idx_reg;
                idx_next = rd_addr;
            end
            eht_pkg::ST_UPD:
            begin
                rd_addr     = idx_reg;
                mem_we      = have_slot;
                p_full_next = !have_slot;
                p_new_next  = is_disc && have_slot && !found_reg;
                p_hs_next   = is_disc && have_slot && hs;
                if (have_slot)
                begin
                    valid_next[wr_addr] = 1'b1;
                end
            end
            eht_pkg::ST_EMIT:
            begin
                load_out = can_load;
                if (p_full_reg)
                begin
                    load_kind = eht_pkg::KIND_FULL;
                    load_id   = id_reg;
                    load_last = 1'b1;
                    if (can_load) p_full_next = 1'b0;
                end
                else if (p_new_reg)
                begin
                    load_kind = eht_pkg::KIND_NEW;
                    load_id   = id_reg;
                    load_last = !p_hs_reg && !p_done_reg;
                    if (can_load) p_new_next = 1'b0;
                end
                else if (p_hs_reg)
                begin
                    load_kind = eht_pkg::KIND_HS;
                    load_id   = id_reg;
                    load_last = !p_done_reg;
                    if (can_load) p_hs_next = 1'b0;
                end
                else
                begin
                    load_kind = eht_pkg::KIND_DONE;
                    load_id   = '0;
                    load_last = 1'b1;
                    if (can_load) p_done_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= eht_pkg::ST_IDLE;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            p_full_reg     <= 1'b0;
            p_new_reg      <= 1'b0;
            p_hs_reg       <= 1'b0;
            p_done_reg     <= 1'b0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            p_full_reg     <= p_full_next;
            p_new_reg      <= p_new_next;
            p_hs_reg       <= p_hs_next;
            p_done_reg     <= p_done_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg  <= eht_pkg::cmd_t'(pop_data[CMD_W-1 -: eht_pkg::CMD_BITS]);
            id_reg   <= pop_data[40 +: ID_BITS];
            rssi_reg <= pop_data[39:32];
            now_reg  <= pop_data[31:0];
        end
        if (load_out)
        begin
            out_kind_reg <= load_kind;
            out_id_reg   <= load_id;
            out_time_reg <= load_time;
            out_last_reg <= load_last;
        end
    end

    // table store, registered read
    always_ff @(posedge clk)
    begin
        rd_dev_reg   <= dev_mem[rd_addr];
        rd_enc_reg   <= enc_mem[rd_addr];
        rd_seen_reg  <= seen_mem[rd_addr];
        rd_first_reg <= first_mem[rd_addr];
        rd_last_reg  <= last_mem[rd_addr];
        if (mem_we)
        begin
            dev_mem[wr_addr]   <= id_reg;
            enc_mem[wr_addr]   <= wr_enc;
            seen_mem[wr_addr]  <= wr_seen;
            first_mem[wr_addr] <= wr_first;
            last_mem[wr_addr]  <= wr_last;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_kind      = out_kind_reg;
    assign out_ch.out_device_id = out_id_reg;
    assign out_ch.out_time_ms   = out_time_reg;
    assign out_ch.out_last      = out_last_reg;

    `EHT_ASSERT(a_write_in_upd, clk, rst_n, !mem_we || (state_reg == eht_pkg::ST_UPD))
    `EHT_ASSERT(a_emit_pending, clk, rst_n,
        (state_reg != eht_pkg::ST_EMIT) || p_full_reg || p_new_reg || p_hs_reg || p_done_reg)
    `EHT_ASSERT(a_full_alone, clk, rst_n, !p_full_reg || (!p_new_reg && !p_hs_reg))
    `EHT_ASSERT_NEXT(a_pop_idle, clk, rst_n, pop, state_reg != eht_pkg::ST_IDLE)
endmodule
